// File: hdl/cppd_pkg.sv
// ----------------------------------------------------------------------------
// cppd_pkg
// shared types, constants and fixed-point helpers for the projection unit
// ----------------------------------------------------------------------------
package cppd_pkg;

    localparam int unsigned DIV_STEPS = 33;
    localparam logic signed [31:0] RADIAL_K3 = 32'sd0;
    localparam logic signed [39:0] Q28_ONE   = 40'sd268435456;
    localparam logic signed [39:0] S32_MAX   = 40'sd2147483647;
    localparam logic signed [39:0] S32_MIN   = -40'sd2147483648;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEPTH = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_RADIAL_C1 = 3'd4,
        REG_RADIAL_C2 = 3'd5,
        REG_TANGENT_1 = 3'd6,
        REG_TANGENT_2 = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic bad;
    } t_div_side;

    typedef struct packed {
        logic [59:0] num;
        logic [30:0] den;
        logic [30:0] rem;
        logic [32:0] quo;
        logic        ovf;
        logic        neg;
    } t_div_lane;

    // signed 32x32 product
    function automatic logic signed [63:0] mul_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        mul_s = 64'(a) * 64'(b);
    endfunction

    // unsigned 32x32 product
    function automatic logic [63:0] mul_u(input logic [31:0] a, input logic [31:0] b);
        mul_u = 64'(a) * 64'(b);
    endfunction

    // round magnitude to nearest by 2^28, sign restored
    function automatic logic signed [39:0] rnd28(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        r = (mag + 64'd134217728) >> 28;
        rnd28 = p[63] ? -40'($signed({1'b0, r[38:0]})) : 40'($signed({1'b0, r[38:0]}));
    endfunction

    function automatic logic ovf32(input logic signed [39:0] v);
        ovf32 = (v > S32_MAX) || (v < S32_MIN);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > S32_MAX) begin
            sat32 = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic t_div_lane div_init(input logic neg, input logic [31:0] mag,
                                           input logic [30:0] den);
        t_div_lane l;
        l.num = {mag, 28'd0} + 60'(den >> 1);
        l.den = den;
        l.ovf = {4'd0, l.num[59:33]} >= den;
        l.rem = {4'd0, l.num[59:33]};
        l.quo = '0;
        l.neg = neg;
        div_init = l;
    endfunction

    // one restoring step, bit b of the numerator shifted in
    function automatic t_div_lane div_step(input t_div_lane a, input logic [5:0] b);
        t_div_lane l;
        logic [31:0] sh;
        l = a;
        sh = {a.rem, a.num[b]};
        if (sh >= {1'b0, a.den}) begin
            l.rem = 31'(sh - {1'b0, a.den});
            l.quo = {a.quo[31:0], 1'b1};
        end else begin
            l.rem = sh[30:0];
            l.quo = {a.quo[31:0], 1'b0};
        end
        div_step = l;
    endfunction

    function automatic logic div_big(input t_div_lane l);
        if (l.neg) begin
            div_big = l.ovf || l.quo[32] || (l.quo[31] && (l.quo[30:0] != '0));
        end else begin
            div_big = l.ovf || l.quo[32] || l.quo[31];
        end
    endfunction

    function automatic logic signed [31:0] div_fin(input t_div_lane l);
        if (div_big(l)) begin
            div_fin = l.neg ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            div_fin = l.neg ? $signed(~l.quo[31:0] + 32'd1) : $signed(l.quo[31:0]);
        end
    endfunction

endpackage

// File: hdl/cppd_pt_if.sv
// ----------------------------------------------------------------------------
// cppd_pt_if
// point request channel: camera-frame point with valid/ready
// ----------------------------------------------------------------------------
interface cppd_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: hdl/cppd_px_if.sv
// ----------------------------------------------------------------------------
// cppd_px_if
// pixel request channel: projected pixel and status with valid/ready
// ----------------------------------------------------------------------------
interface cppd_px_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic [1:0]         result_status;

    modport source (output valid, pixel_u, pixel_v, result_status, input ready);
    modport sink (input valid, pixel_u, pixel_v, result_status, output ready);
endinterface

// File: hdl/camera_point_projection_distortion_unit.sv
// ----------------------------------------------------------------------------
// camera_point_projection_distortion_unit
// pinhole projection of a camera-frame point with brown-conrady distortion
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// i_pt      in   valid/ready   point_x, point_y, point_z (signed int)
// o_px      out  valid/ready   pixel_u, pixel_v (q16.16), result_status
// i_cfg_*   in   write enable  index 0..7, 32-bit data
//
// one request per cycle while the output is not stalled; the path runs through the divider
// and then the multiply/round/saturate stages
// the whole pipeline advances together; it holds when the output register
// is full and not taken, so ready falls only under backpressure
// synchronous active-low reset clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module camera_point_projection_distortion_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cppd_pt_if.sink     i_pt,
    cppd_px_if.source   o_px,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0]        r_focal_x, r_focal_y;
    logic signed [31:0] r_center_x, r_center_y;
    logic signed [31:0] r_k1, r_k2, r_p1, r_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 32'd65536;
            r_focal_y  <= 32'd65536;
            r_center_x <= '0;
            r_center_y <= '0;
            r_k1       <= '0;
            r_k2       <= '0;
            r_p1       <= '0;
            r_p2       <= '0;
        end else if (i_cfg_we) begin
            case (cppd_pkg::t_reg_idx'(i_cfg_idx))
                cppd_pkg::REG_FOCAL_X:   r_focal_x  <= i_cfg_data;
                cppd_pkg::REG_FOCAL_Y:   r_focal_y  <= i_cfg_data;
                cppd_pkg::REG_CENTER_X:  r_center_x <= i_cfg_data;
                cppd_pkg::REG_CENTER_Y:  r_center_y <= i_cfg_data;
                cppd_pkg::REG_RADIAL_C1: r_k1       <= i_cfg_data;
                cppd_pkg::REG_RADIAL_C2: r_k2       <= i_cfg_data;
                cppd_pkg::REG_TANGENT_1: r_p1       <= i_cfg_data;
                cppd_pkg::REG_TANGENT_2: r_p2       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: output slot empty or being taken
    logic w_en;
    logic [14:1] r_vld;
    assign w_en       = !r_vld[14] || o_px.ready;
    assign i_pt.ready = w_en;

    // entry: depth check and magnitudes for the divider
    cppd_pkg::t_div_side w_side, w_dside;
    logic               w_bad;
    logic signed [31:0] w_dx, w_dy;
    logic               w_dsat;

    assign w_bad        = i_pt.point_z[31] || (i_pt.point_z == '0);
    assign w_side.valid = i_pt.valid;
    assign w_side.bad   = w_bad;

    cppd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_side),
        .i_neg_x (i_pt.point_x[31]),
        .i_mag_x (i_pt.point_x[31] ? ~i_pt.point_x + 32'd1 : i_pt.point_x),
        .i_neg_y (i_pt.point_y[31]),
        .i_mag_y (i_pt.point_y[31] ? ~i_pt.point_y + 32'd1 : i_pt.point_y),
        .i_den   (i_pt.point_z[30:0]),
        .o_side  (w_dside),
        .o_x     (w_dx),
        .o_y     (w_dy),
        .o_sat   (w_dsat)
    );

    // status side band travels with the valid bits
    logic [13:1] r_bad, r_sat;

    // stage registers
    logic signed [31:0] r1_x, r1_y;
    logic signed [63:0] r1_pxx, r1_pyy, r1_pxy;
    logic signed [31:0] r2_x, r2_y, r2_xx, r2_yy, r2_xy;
    logic signed [31:0] r3_x, r3_y, r3_xx, r3_yy, r3_xy, r3_r2;
    logic signed [31:0] r4_x, r4_y, r4_r2, r4_tx, r4_ty;
    logic signed [63:0] r4_pr4, r4_pk1, r4_pp1xy, r4_pp2xy;
    logic signed [31:0] r5_x, r5_y, r5_r2, r5_r4;
    logic signed [39:0] r5_k1r2, r5_p1xy, r5_p2xy;
    logic signed [63:0] r5_pp2tx, r5_pp1ty;
    logic signed [31:0] r6_x, r6_y, r6_xt, r6_yt;
    logic signed [39:0] r6_k1r2;
    logic signed [63:0] r6_pr6, r6_pk2;
    logic signed [31:0] r7_x, r7_y, r7_xt, r7_yt, r7_r6;
    logic signed [39:0] r7_k1r2, r7_k2r4;
    logic signed [31:0] r8_x, r8_y, r8_xt, r8_yt;
    logic signed [39:0] r8_k1r2, r8_k2r4;
    logic signed [63:0] r8_pk3;
    logic signed [31:0] r9_x, r9_y, r9_xt, r9_yt, r9_rad;
    logic signed [31:0] r10_xt, r10_yt;
    logic signed [63:0] r10_pxr, r10_pyr;
    logic signed [31:0] r11_xt, r11_yt, r11_xr, r11_yr;
    logic signed [31:0] r12_xd, r12_yd;
    logic [63:0]        r13_mu, r13_mv;
    logic               r13_nu, r13_nv;
    logic signed [31:0] r14_u, r14_v;
    logic [1:0]         r14_st;

    // combinational terms kept out of the clocked block
    logic signed [39:0] w2_xx, w2_yy, w2_xy, w3_r2, w4_tx, w4_ty;
    logic signed [39:0] w5_r4, w6_xt, w6_yt, w7_r6, w9_rad;
    logic signed [39:0] w11_xr, w11_yr, w12_xd, w12_yd, w14_u, w14_v;
    logic [63:0]        w14_ru, w14_rv;
    logic [31:0]        w13_au, w13_av;

    assign w2_xx  = cppd_pkg::rnd28(r1_pxx);
    assign w2_yy  = cppd_pkg::rnd28(r1_pyy);
    assign w2_xy  = cppd_pkg::rnd28(r1_pxy);
    assign w3_r2  = 40'(r2_xx) + 40'(r2_yy);
    assign w4_tx  = 40'(r3_r2) + 40'(r3_xx) + 40'(r3_xx);
    assign w4_ty  = 40'(r3_r2) + 40'(r3_yy) + 40'(r3_yy);
    assign w5_r4  = cppd_pkg::rnd28(r4_pr4);
    // tangential: 2*p1*xy + p2*(r2 + 2x^2), p1*(r2 + 2y^2) + 2*p2*xy
    assign w6_xt  = r5_p1xy + r5_p1xy + cppd_pkg::rnd28(r5_pp2tx);
    assign w6_yt  = cppd_pkg::rnd28(r5_pp1ty) + r5_p2xy + r5_p2xy;
    assign w7_r6  = cppd_pkg::rnd28(r6_pr6);
    assign w9_rad = cppd_pkg::Q28_ONE + r8_k1r2 + r8_k2r4 + cppd_pkg::rnd28(r8_pk3);
    assign w11_xr = cppd_pkg::rnd28(r10_pxr);
    assign w11_yr = cppd_pkg::rnd28(r10_pyr);
    assign w12_xd = 40'(r11_xr) + 40'(r11_xt);
    assign w12_yd = 40'(r11_yr) + 40'(r11_yt);
    assign w13_au = r12_xd[31] ? ~r12_xd + 32'd1 : r12_xd;
    assign w13_av = r12_yd[31] ? ~r12_yd + 32'd1 : r12_yd;
    // pixel: rounded magnitude of focal * distorted coordinate, plus center
    assign w14_ru = (r13_mu + 64'd134217728) >> 28;
    assign w14_rv = (r13_mv + 64'd134217728) >> 28;
    assign w14_u  = (r13_nu ? -40'($signed({1'b0, w14_ru[38:0]}))
                            : 40'($signed({1'b0, w14_ru[38:0]}))) + 40'(r_center_x);
    assign w14_v  = (r13_nv ? -40'($signed({1'b0, w14_rv[38:0]}))
                            : 40'($signed({1'b0, w14_rv[38:0]}))) + 40'(r_center_y);

    // valid and status bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[13:1], w_dside.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bad <= {r_bad[12:1], w_dside.bad};
            r_sat[1]  <= w_dsat;
            r_sat[2]  <= r_sat[1] | cppd_pkg::ovf32(w2_xx) | cppd_pkg::ovf32(w2_yy)
                       | cppd_pkg::ovf32(w2_xy);
            r_sat[3]  <= r_sat[2] | cppd_pkg::ovf32(w3_r2);
            r_sat[4]  <= r_sat[3] | cppd_pkg::ovf32(w4_tx) | cppd_pkg::ovf32(w4_ty);
            r_sat[5]  <= r_sat[4] | cppd_pkg::ovf32(w5_r4);
            r_sat[6]  <= r_sat[5] | cppd_pkg::ovf32(w6_xt) | cppd_pkg::ovf32(w6_yt);
            r_sat[7]  <= r_sat[6] | cppd_pkg::ovf32(w7_r6);
            r_sat[8]  <= r_sat[7];
            r_sat[9]  <= r_sat[8] | cppd_pkg::ovf32(w9_rad);
            r_sat[10] <= r_sat[9];
            r_sat[11] <= r_sat[10] | cppd_pkg::ovf32(w11_xr) | cppd_pkg::ovf32(w11_yr);
            r_sat[12] <= r_sat[11] | cppd_pkg::ovf32(w12_xd) | cppd_pkg::ovf32(w12_yd);
            r_sat[13] <= r_sat[12];
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // squares and cross term
            r1_x   <= w_dx;
            r1_y   <= w_dy;
            r1_pxx <= cppd_pkg::mul_s(w_dx, w_dx);
            r1_pyy <= cppd_pkg::mul_s(w_dy, w_dy);
            r1_pxy <= cppd_pkg::mul_s(w_dx, w_dy);
            // rescale
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_xx <= cppd_pkg::sat32(w2_xx);
            r2_yy <= cppd_pkg::sat32(w2_yy);
            r2_xy <= cppd_pkg::sat32(w2_xy);
            // r squared
            r3_x  <= r2_x;
            r3_y  <= r2_y;
            r3_xx <= r2_xx;
            r3_yy <= r2_yy;
            r3_xy <= r2_xy;
            r3_r2 <= cppd_pkg::sat32(w3_r2);
            // r4, k1 term, tangential cross products
            r4_x     <= r3_x;
            r4_y     <= r3_y;
            r4_r2    <= r3_r2;
            r4_tx    <= cppd_pkg::sat32(w4_tx);
            r4_ty    <= cppd_pkg::sat32(w4_ty);
            r4_pr4   <= cppd_pkg::mul_s(r3_r2, r3_r2);
            r4_pk1   <= cppd_pkg::mul_s(r_k1, r3_r2);
            r4_pp1xy <= cppd_pkg::mul_s(r_p1, r3_xy);
            r4_pp2xy <= cppd_pkg::mul_s(r_p2, r3_xy);
            r5_x     <= r4_x;
            r5_y     <= r4_y;
            r5_r2    <= r4_r2;
            r5_r4    <= cppd_pkg::sat32(w5_r4);
            r5_k1r2  <= cppd_pkg::rnd28(r4_pk1);
            r5_p1xy  <= cppd_pkg::rnd28(r4_pp1xy);
            r5_p2xy  <= cppd_pkg::rnd28(r4_pp2xy);
            r5_pp2tx <= cppd_pkg::mul_s(r_p2, r4_tx);
            r5_pp1ty <= cppd_pkg::mul_s(r_p1, r4_ty);
            // r6, k2 term, tangential sums
            r6_x    <= r5_x;
            r6_y    <= r5_y;
            r6_xt   <= cppd_pkg::sat32(w6_xt);
            r6_yt   <= cppd_pkg::sat32(w6_yt);
            r6_k1r2 <= r5_k1r2;
            r6_pr6  <= cppd_pkg::mul_s(r5_r4, r5_r2);
            r6_pk2  <= cppd_pkg::mul_s(r_k2, r5_r4);
            r7_x    <= r6_x;
            r7_y    <= r6_y;
            r7_xt   <= r6_xt;
            r7_yt   <= r6_yt;
            r7_r6   <= cppd_pkg::sat32(w7_r6);
            r7_k1r2 <= r6_k1r2;
            r7_k2r4 <= cppd_pkg::rnd28(r6_pk2);
            // k3 term
            r8_x    <= r7_x;
            r8_y    <= r7_y;
            r8_xt   <= r7_xt;
            r8_yt   <= r7_yt;
            r8_k1r2 <= r7_k1r2;
            r8_k2r4 <= r7_k2r4;
            r8_pk3  <= cppd_pkg::mul_s(cppd_pkg::RADIAL_K3, r7_r6);
            // radial factor
            r9_x   <= r8_x;
            r9_y   <= r8_y;
            r9_xt  <= r8_xt;
            r9_yt  <= r8_yt;
            r9_rad <= cppd_pkg::sat32(w9_rad);
            r10_xt  <= r9_xt;
            r10_yt  <= r9_yt;
            r10_pxr <= cppd_pkg::mul_s(r9_x, r9_rad);
            r10_pyr <= cppd_pkg::mul_s(r9_y, r9_rad);
            r11_xt <= r10_xt;
            r11_yt <= r10_yt;
            r11_xr <= cppd_pkg::sat32(w11_xr);
            r11_yr <= cppd_pkg::sat32(w11_yr);
            // distorted normalized coordinate
            r12_xd <= cppd_pkg::sat32(w12_xd);
            r12_yd <= cppd_pkg::sat32(w12_yd);
            // focal scaling on magnitudes
            r13_mu <= cppd_pkg::mul_u(r_focal_x, w13_au);
            r13_mv <= cppd_pkg::mul_u(r_focal_y, w13_av);
            r13_nu <= r12_xd[31];
            r13_nv <= r12_yd[31];
            // output register
            if (r_bad[13]) begin
                r14_u  <= '0;
                r14_v  <= '0;
                r14_st <= cppd_pkg::ST_DEPTH;
            end else begin
                r14_u  <= cppd_pkg::sat32(w14_u);
                r14_v  <= cppd_pkg::sat32(w14_v);
                r14_st <= (r_sat[13] | cppd_pkg::ovf32(w14_u) | cppd_pkg::ovf32(w14_v))
                        ? cppd_pkg::ST_SAT : cppd_pkg::ST_OK;
            end
        end
    end

    assign o_px.valid         = r_vld[14];
    assign o_px.pixel_u       = r14_u;
    assign o_px.pixel_v       = r14_v;
    assign o_px.result_status = r14_st;

`ifndef SYNTHESIS
    // a depth error never carries a pixel
    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && (o_px.result_status == cppd_pkg::ST_DEPTH))
            |-> (o_px.pixel_u == '0 && o_px.pixel_v == '0))
        else $error("depth error with nonzero pixel");

    // backpressure on the output closes the input
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && !o_px.ready) |-> !i_pt.ready)
        else $error("input ready while output stalled");

    // a stalled pipeline keeps every valid bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during stall");
`endif

endmodule

// File: hdl/cppd_div.sv
// ----------------------------------------------------------------------------
// cppd_div
// two-lane pipelined restoring divider, one quotient bit per stage, q4.28 out
// ----------------------------------------------------------------------------
module cppd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cppd_pkg::t_div_side         i_side,
    input  logic                        i_neg_x,
    input  logic [31:0]                 i_mag_x,
    input  logic                        i_neg_y,
    input  logic [31:0]                 i_mag_y,
    input  logic [30:0]                 i_den,
    output cppd_pkg::t_div_side         o_side,
    output logic signed [31:0]          o_x,
    output logic signed [31:0]          o_y,
    output logic                        o_sat
);

    cppd_pkg::t_div_lane r_lx [0:cppd_pkg::DIV_STEPS];
    cppd_pkg::t_div_lane r_ly [0:cppd_pkg::DIV_STEPS];
    cppd_pkg::t_div_side r_sd [0:cppd_pkg::DIV_STEPS];
    cppd_pkg::t_div_side r_out_sd;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic                r_sat;

    // side band with valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= cppd_pkg::DIV_STEPS; s++) begin
                r_sd[s] <= '0;
            end
            r_out_sd <= '0;
        end else if (i_en) begin
            r_sd[0] <= i_side;
            for (int s = 1; s <= cppd_pkg::DIV_STEPS; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
            r_out_sd <= r_sd[cppd_pkg::DIV_STEPS];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lx[0] <= cppd_pkg::div_init(i_neg_x, i_mag_x, i_den);
            r_ly[0] <= cppd_pkg::div_init(i_neg_y, i_mag_y, i_den);
            for (int s = 1; s <= cppd_pkg::DIV_STEPS; s++) begin
                r_lx[s] <= cppd_pkg::div_step(r_lx[s-1], 6'(cppd_pkg::DIV_STEPS - s));
                r_ly[s] <= cppd_pkg::div_step(r_ly[s-1], 6'(cppd_pkg::DIV_STEPS - s));
            end
            r_x   <= cppd_pkg::div_fin(r_lx[cppd_pkg::DIV_STEPS]);
            r_y   <= cppd_pkg::div_fin(r_ly[cppd_pkg::DIV_STEPS]);
            r_sat <= cppd_pkg::div_big(r_lx[cppd_pkg::DIV_STEPS])
                   | cppd_pkg::div_big(r_ly[cppd_pkg::DIV_STEPS]);
        end
    end

    assign o_side = r_out_sd;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_sat  = r_sat;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks camera_point_projection_distortion_unit against an in-bench
// fixed-point projection over directed and random points and lens settings
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 drain;   // hold off until the pipeline is empty
    } t_point;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        cppd_pkg::t_status  status;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    cppd_pt_if pt_ch ();
    cppd_px_if px_ch ();

    camera_point_projection_distortion_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_ch.sink),
        .o_px       (px_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // lens settings as the bench believes them to be
    logic [31:0] lens_reg [8];

    t_point point_queue [$];
    t_pixel pixel_queue [$];
    int     n_sent;
    int     n_checked;
    int     n_errors;
    int     n_depth;
    int     n_sat;
    int     n_cycles;
    bit     calm;            // stretch with no idling on either side

    // ------------------------------------------------------------------------
    // projection predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp32(longint v, ref bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // round to nearest by 2^28 on the magnitude, ties away from zero
    function automatic longint round28(longint p);
        longint mag;
        mag = (p < 0) ? -p : p;
        mag = (mag + 64'sd134217728) >>> 28;
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round28(a * b);
    endfunction

    function automatic longint qdiv(longint num, longint den, ref bit flag);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = ((mag <<< 28) + (den >>> 1)) / den;
        return clamp32((num < 0) ? -q : q, flag);
    endfunction

    function automatic longint pixel_of(logic [31:0] focal, longint d,
                                        logic signed [31:0] center, ref bit flag);
        longint fm;
        longint dm;
        longint r;
        fm = longint'({32'd0, focal});
        dm = (d < 0) ? -d : d;
        r  = round28(fm * dm);
        if (d < 0) r = -r;
        return clamp32(r + longint'(center), flag);
    endfunction

    function automatic t_pixel project_point(t_point p);
        t_pixel res;
        bit     sat;
        longint k1, k2, k3, t1, t2;
        longint x, y, xx, yy, xy, r2, r4, r6, radial, xr, yr, tv, xt, yt, xd, yd;
        sat = 1'b0;
        if (p.z <= 0) begin
            res.u = '0;
            res.v = '0;
            res.status = cppd_pkg::ST_DEPTH;
            return res;
        end
        k1 = longint'($signed(lens_reg[cppd_pkg::REG_RADIAL_C1]));
        k2 = longint'($signed(lens_reg[cppd_pkg::REG_RADIAL_C2]));
        t1 = longint'($signed(lens_reg[cppd_pkg::REG_TANGENT_1]));
        t2 = longint'($signed(lens_reg[cppd_pkg::REG_TANGENT_2]));
        k3 = longint'(cppd_pkg::RADIAL_K3);

        // normalized coordinates
        x = qdiv(longint'(p.x), longint'(p.z), sat);
        y = qdiv(longint'(p.y), longint'(p.z), sat);

        xx = clamp32(qmul(x, x), sat);
        yy = clamp32(qmul(y, y), sat);
        xy = clamp32(qmul(x, y), sat);
        r2 = clamp32(xx + yy, sat);
        r4 = clamp32(qmul(r2, r2), sat);
        r6 = clamp32(qmul(r4, r2), sat);

        // radial polynomial on the clamped powers
        radial = clamp32(64'sd268435456 + qmul(k1, r2) + qmul(k2, r4) + qmul(k3, r6), sat);
        xr = clamp32(qmul(x, radial), sat);
        yr = clamp32(qmul(y, radial), sat);

        // tangential terms
        tv = clamp32(r2 + 2 * xx, sat);
        xt = clamp32(2 * qmul(t1, xy) + qmul(t2, tv), sat);
        tv = clamp32(r2 + 2 * yy, sat);
        yt = clamp32(qmul(t1, tv) + 2 * qmul(t2, xy), sat);

        xd = clamp32(xr + xt, sat);
        yd = clamp32(yr + yt, sat);

        res.u = 32'(pixel_of(lens_reg[cppd_pkg::REG_FOCAL_X], xd,
                             $signed(lens_reg[cppd_pkg::REG_CENTER_X]), sat));
        res.v = 32'(pixel_of(lens_reg[cppd_pkg::REG_FOCAL_Y], yd,
                             $signed(lens_reg[cppd_pkg::REG_CENTER_Y]), sat));
        res.status = sat ? cppd_pkg::ST_SAT : cppd_pkg::ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on pixel %0d: %s got %h expected %h", n_checked, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------------
    // point driver: one request per accepted handshake, random gaps
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point nxt;
        bit     take;
        if (!i_rst_n) begin
            pt_ch.valid <= 1'b0;
        end else begin
            if (pt_ch.valid && pt_ch.ready) begin
                // prediction made with the settings in force at acceptance
                pixel_queue.push_back(project_point('{pt_ch.point_x, pt_ch.point_y,
                                                       pt_ch.point_z, 1'b0}));
                n_sent++;
            end
            if (!pt_ch.valid || pt_ch.ready) begin
                take = (point_queue.size() != 0) && (calm || $urandom_range(99) >= 29);
                // a drain request waits for every outstanding pixel
                if (take && point_queue[0].drain && (pixel_queue.size() != 0))
                    take = 1'b0;
                if (take) begin
                    nxt = point_queue.pop_front();
                    pt_ch.valid   <= 1'b1;
                    pt_ch.point_x <= nxt.x;
                    pt_ch.point_y <= nxt.y;
                    pt_ch.point_z <= nxt.z;
                end else begin
                    pt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel monitor: random backpressure, field-by-field compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            px_ch.ready <= 1'b0;
        end else begin
            if (px_ch.valid && px_ch.ready) begin
                if (pixel_queue.size() == 0) begin
                    $display("unexpected pixel request u=%h v=%h", px_ch.pixel_u, px_ch.pixel_v);
                    n_errors++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (px_ch.pixel_u !== want.u)
                        report_mismatch("pixel_u", px_ch.pixel_u, want.u);
                    if (px_ch.pixel_v !== want.v)
                        report_mismatch("pixel_v", px_ch.pixel_v, want.v);
                    if (px_ch.result_status !== want.status)
                        report_mismatch("status", 32'(px_ch.result_status), 32'(want.status));
                    if (want.status == cppd_pkg::ST_DEPTH) n_depth++;
                    if (want.status == cppd_pkg::ST_SAT) n_sat++;
                    n_checked++;
                end
            end
            px_ch.ready <= calm || ($urandom_range(99) >= 29);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > 2000000) begin
            $display("timeout with %0d pixels outstanding", pixel_queue.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit drain = 0);
        point_queue.push_back('{x, y, z, drain});
    endtask

    task automatic write_lens(cppd_pkg::t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        lens_reg[idx] = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every request has gone through, plus the pipeline latency
    task automatic wait_idle();
        while (point_queue.size() != 0 || pt_ch.valid || pixel_queue.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [31:0] small_coef();
        return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endfunction

    // mostly points in front of the camera with a sane field of view
    task automatic add_random_points(int n);
        logic [31:0] z;
        int          mode;
        repeat (n) begin
            mode = $urandom_range(99);
            if (mode < 70) begin
                z = $urandom_range(1, 32'h0010_0000);
                add_point(32'($signed($urandom_range(0, 4 * z))) - 32'(2 * z),
                          32'($signed($urandom_range(0, 4 * z))) - 32'(2 * z), z);
            end else if (mode < 80) begin
                add_point($urandom, $urandom, 32'($urandom_range(1, 64)));
            end else if (mode < 88) begin
                add_point($urandom, $urandom, -32'($urandom_range(0, 100)));
            end else begin
                add_point($urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic run_setting(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                               logic [31:0] cy, logic [31:0] k1, logic [31:0] k2,
                               logic [31:0] t1, logic [31:0] t2, int n);
        wait_idle();
        write_lens(cppd_pkg::REG_FOCAL_X, fx);
        write_lens(cppd_pkg::REG_FOCAL_Y, fy);
        write_lens(cppd_pkg::REG_CENTER_X, cx);
        write_lens(cppd_pkg::REG_CENTER_Y, cy);
        write_lens(cppd_pkg::REG_RADIAL_C1, k1);
        write_lens(cppd_pkg::REG_RADIAL_C2, k2);
        write_lens(cppd_pkg::REG_TANGENT_1, t1);
        write_lens(cppd_pkg::REG_TANGENT_2, t2);
        add_random_points(n);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        pt_ch.valid   = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        pt_ch.point_z = '0;
        px_ch.ready   = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        foreach (lens_reg[i]) lens_reg[i] = 32'd0;
        lens_reg[cppd_pkg::REG_FOCAL_X] = 32'd65536;
        lens_reg[cppd_pkg::REG_FOCAL_Y] = 32'd65536;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed points with reset settings
        add_point(32'd0, 32'd0, 32'd1);
        add_point(32'd3, -32'd5, 32'd7);
        add_point(32'h7fff_ffff, 32'h7fff_ffff, 32'd1);           // normalized clamp
        add_point(32'h8000_0000, 32'h8000_0000, 32'd1);
        add_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        add_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        add_point(32'd5, 32'd5, 32'd0);                           // zero depth
        add_point(32'd5, 32'd5, 32'h8000_0000);                   // negative depth
        add_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_point(32'd1, 32'd1, 32'd2);                           // exact half rounding
        add_point(-32'd1, -32'd1, 32'd2);
        add_point(32'd16, -32'd16, 32'd1);
        add_point(32'd7, 32'd8, 32'd8, 1'b1);                     // wait for empty pipe
        add_point(32'd1000, -32'd2000, 32'd1500);

        // extreme lens settings
        run_setting(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        add_point(32'd1, 32'd1, 32'd1);
        add_point(32'd1, 32'd2, 32'd1000);
        add_point(-32'd3, 32'd4, 32'd5);
        run_setting(32'd0, 32'd0, 32'h8000_0000, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_point(32'd1, 32'd1, 32'd1);
        add_point(-32'd3, 32'd4, 32'd5);
        add_point(32'd9, -32'd9, 32'd3);

        // realistic camera settings with random content
        run_setting(32'd600 << 16, 32'd600 << 16, 32'd320 << 16, 32'd240 << 16,
                    small_coef(), small_coef(), small_coef() >>> 4, small_coef() >>> 4, 250);
        add_point(32'd2, 32'd3, 32'd4, 1'b1);
        calm = 1'b1;
        add_random_points(200);
        wait_idle();
        calm = 1'b0;
        run_setting($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, 200);
        run_setting($urandom_range(0, 32'h0800_0000), $urandom_range(0, 32'h0800_0000),
                    $urandom, $urandom, small_coef(), small_coef(), small_coef(),
                    small_coef(), 300);
        run_setting(32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 270);

        wait_idle();
        $display("%0d points sent, %0d pixels checked (%0d depth errors, %0d saturated)",
                 n_sent, n_checked, n_depth, n_sat);
        $display("covered reset, extreme and random lens settings with random backpressure");
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cppd_pkg.sv
hdl/cppd_pt_if.sv
hdl/cppd_px_if.sv
hdl/cppd_div.sv
hdl/camera_point_projection_distortion_unit.sv
sim/testbench.sv
